/* src/line_edit_buffer_core_macros.svh */
// Assertion macros used by the sequencer (lec_ctrl) of the line edit buffer.
// Needs no other file; the bodies are empty when SYNTHESIS is defined.
`ifndef LINE_EDIT_BUFFER_CORE_MACROS_SVH
`define LINE_EDIT_BUFFER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LEC_ASSERT_IMPL(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("line_edit_buffer_core: same-cycle check failed");
`define LEC_ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("line_edit_buffer_core: next-cycle check failed");
`else
`define LEC_ASSERT_IMPL(name, clk, rst, pre, post)
`define LEC_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

/* src/lec_pkg.sv */
// Package of the line edit buffer: sizes, key codes, operation codes and types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lec_pkg;

  localparam int MaxWidth = 64;
  localparam int IdxW     = $clog2(MaxWidth);
  localparam int PosW     = $clog2(MaxWidth + 1);
  localparam int CharW    = 8;
  localparam int ActW     = 2;
  localparam int CfgW     = 7;

  localparam logic [CharW-1:0] KeyPrefixNul = 8'h00;
  localparam logic [CharW-1:0] KeyPrefixExt = 8'hE0;
  localparam logic [CharW-1:0] KeyBackspace = 8'h08;
  localparam logic [CharW-1:0] KeyEnter     = 8'd13;
  localparam logic [CharW-1:0] KeyCtrlMax   = 8'd31;
  localparam logic [CharW-1:0] ScanDelete   = 8'd83;
  localparam logic [CharW-1:0] ScanLeft     = 8'd75;
  localparam logic [CharW-1:0] ScanRight    = 8'd77;
  localparam logic [CharW-1:0] ScanHome     = 8'd71;
  localparam logic [CharW-1:0] ScanEnd      = 8'd79;
  localparam logic [CharW-1:0] ScanInsert   = 8'd82;
  localparam logic [CharW-1:0] CharSpace    = 8'h20;

  typedef enum logic [ActW-1:0] {
    ACT_KEY   = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_START = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PREFIX,
    OP_LOAD,
    OP_READ,
    OP_START,
    OP_BKSP,
    OP_DEL,
    OP_LEFT,
    OP_RIGHT,
    OP_HOME,
    OP_END,
    OP_INS,
    OP_PRINT,
    OP_ENTER
  } op_t;

  typedef struct packed {
    logic             shift;
    logic [CharW-1:0] tail;
  } chain_ctl_t;

  typedef struct packed {
    logic [CharW-1:0] head;
    logic [CharW-1:0] next;
  } chain_tap_t;

  typedef struct packed {
    logic [PosW-1:0]  cursor;
    logic             insert_mode;
    logic             bell;
    logic             done_res;
    logic [PosW-1:0]  line_length;
    logic [CharW-1:0] read_char;
  } result_t;

  function automatic op_t scan_op(input logic [CharW-1:0] code);
    op_t op;
    op = OP_NONE;
    if (code == KeyBackspace)    op = OP_BKSP;
    else if (code == ScanDelete) op = OP_DEL;
    else if (code == ScanLeft)   op = OP_LEFT;
    else if (code == ScanRight)  op = OP_RIGHT;
    else if (code == ScanHome)   op = OP_HOME;
    else if (code == ScanEnd)    op = OP_END;
    else if (code == ScanInsert) op = OP_INS;
    return op;
  endfunction

endpackage

/* src/lec_cell.sv */
// One character cell of the rotating line store.
// Depends on lec_pkg for the character width.
`timescale 1ns / 1ps

module lec_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [lec_pkg::CharW-1:0] din,
  output logic [lec_pkg::CharW-1:0] dout
);

  logic [lec_pkg::CharW-1:0] char_q;

  always_ff @(posedge clk) begin
    if (shift) begin
      char_q <= din;
    end
  end

  assign dout = char_q;

endmodule

/* src/lec_chain.sv */
// Ring of character cells; each shift moves every character one cell toward the head.
// Depends on lec_pkg and lec_cell.
`timescale 1ns / 1ps

module lec_chain (
  input  logic                clk,
  input  lec_pkg::chain_ctl_t ctl,
  output lec_pkg::chain_tap_t tap
);

  logic [lec_pkg::CharW-1:0] chars [lec_pkg::MaxWidth];

  genvar k;
  generate
    for (k = 0; k < lec_pkg::MaxWidth; k++) begin : g_cell
      if (k == lec_pkg::MaxWidth - 1) begin : g_last
        lec_cell u_cell (
          .clk  (clk),
          .shift(ctl.shift),
          .din  (ctl.tail),
          .dout (chars[k])
        );
      end else begin : g_mid
        lec_cell u_cell (
          .clk  (clk),
          .shift(ctl.shift),
          .din  (chars[k+1]),
          .dout (chars[k])
        );
      end
    end
  endgenerate

  assign tap.head = chars[0];
  assign tap.next = chars[1];

endmodule

/* src/lec_ctrl.sv */
// Sequencer of the line edit buffer: decodes an item, rotates the cell ring once
// while editing the stream at the head, then commits cursor and mode. Uses lec_pkg.
`timescale 1ns / 1ps
`include "line_edit_buffer_core_macros.svh"

module lec_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lec_pkg::ActW-1:0]   action,
  input  logic [lec_pkg::CharW-1:0]  key_byte,
  input  logic [lec_pkg::IdxW-1:0]   char_index,
  input  logic [lec_pkg::CharW-1:0]  char_value,
  input  logic [lec_pkg::CfgW-1:0]   edit_width,
  input  lec_pkg::chain_tap_t        tap,
  output lec_pkg::chain_ctl_t        ctl,
  input  logic                       out_free,
  output logic                       res_load,
  output lec_pkg::result_t           res
);

  localparam int PosW  = lec_pkg::PosW;
  localparam int IdxW  = lec_pkg::IdxW;
  localparam int CharW = lec_pkg::CharW;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_ROTATE = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t            state;
  logic [IdxW-1:0]   cnt;
  lec_pkg::op_t      op;
  lec_pkg::op_t      op_dec;
  logic [CharW-1:0]  key_q;
  logic [IdxW-1:0]   idx_q;
  logic [CharW-1:0]  val_q;
  logic [PosW-1:0]   cursor;
  logic              insert_flag;
  logic              prefix_pending;
  logic [CharW-1:0]  prev;
  logic              del_go;
  logic              right_ok;
  logic              nul_found;
  logic [PosW-1:0]   nul_idx;
  logic [CharW-1:0]  rd;

  logic              accept;
  logic [PosW-1:0]   w;
  logic [PosW-1:0]   w_m1;
  logic [PosW-1:0]   t;
  logic [PosW:0]     pos_inc;
  logic [PosW-1:0]   shift_from;
  logic              del_hit;
  logic              left_active;
  logic [PosW-1:0]   nul_len;
  logic [PosW-1:0]   cursor_next;
  logic              mode_next;
  logic              bell;
  logic              done;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    if (edit_width == '0) begin
      w = PosW'(1);
    end else if (edit_width > lec_pkg::CfgW'(lec_pkg::MaxWidth)) begin
      w = PosW'(lec_pkg::MaxWidth);
    end else begin
      w = PosW'(edit_width);
    end
  end

  assign w_m1       = w - PosW'(1);
  assign t          = PosW'(cnt);
  assign pos_inc    = {1'b0, cursor} + (PosW+1)'(1);
  assign shift_from = cursor - PosW'(1);
  assign nul_len    = nul_found ? nul_idx : w;

  always_comb begin
    op_dec = lec_pkg::OP_NONE;
    unique case (action)
      lec_pkg::ACT_KEY: begin
        priority if (prefix_pending) begin
          op_dec = lec_pkg::scan_op(key_byte);
        end else if (key_byte == lec_pkg::KeyPrefixNul ||
                     key_byte == lec_pkg::KeyPrefixExt) begin
          op_dec = lec_pkg::OP_PREFIX;
        end else if (key_byte == lec_pkg::KeyBackspace) begin
          op_dec = lec_pkg::OP_BKSP;
        end else if (key_byte == lec_pkg::KeyEnter) begin
          op_dec = lec_pkg::OP_ENTER;
        end else if (key_byte > lec_pkg::KeyCtrlMax) begin
          op_dec = lec_pkg::OP_PRINT;
        end else begin
          op_dec = lec_pkg::OP_NONE;
        end
      end
      lec_pkg::ACT_LOAD:  op_dec = lec_pkg::OP_LOAD;
      lec_pkg::ACT_READ:  op_dec = lec_pkg::OP_READ;
      lec_pkg::ACT_START: op_dec = lec_pkg::OP_START;
      default:            op_dec = lec_pkg::OP_NONE;
    endcase
  end

  // The head of the ring is original entry t; whatever goes into the tail
  // becomes the new entry t once the full turn is over.
  // A backspace with the cursor beyond the width still puts a space in the
  // last position.
  always_comb begin
    ctl.shift   = (state == ST_ROTATE);
    ctl.tail    = tap.head;
    del_hit     = 1'b0;
    left_active = 1'b0;
    unique case (op)
      lec_pkg::OP_LOAD: begin
        if (cnt == idx_q) ctl.tail = val_q;
      end
      lec_pkg::OP_BKSP: begin
        left_active = (cursor != '0) && ((t >= shift_from) || (t == w_m1));
      end
      lec_pkg::OP_DEL: begin
        del_hit     = (t == cursor) && (tap.head != '0) && (cursor < w);
        left_active = del_hit || del_go;
      end
      lec_pkg::OP_PRINT: begin
        if (cursor < w) begin
          if (t == cursor) begin
            ctl.tail = key_q;
          end else if (insert_flag && t > cursor && t < w) begin
            ctl.tail = prev;
          end
        end
      end
      default: begin
        ctl.tail = tap.head;
      end
    endcase
    if (left_active) begin
      if (t < w_m1) begin
        ctl.tail = tap.next;
      end else if (t == w_m1) begin
        ctl.tail = lec_pkg::CharSpace;
      end
    end
  end

  always_comb begin
    cursor_next = cursor;
    mode_next   = insert_flag;
    bell        = 1'b0;
    done        = 1'b0;
    unique case (op)
      lec_pkg::OP_BKSP, lec_pkg::OP_LEFT: begin
        if (cursor != '0) cursor_next = cursor - PosW'(1);
        else bell = 1'b1;
      end
      lec_pkg::OP_DEL: begin
        bell = !del_go;
      end
      lec_pkg::OP_RIGHT: begin
        if (pos_inc < {1'b0, w} && right_ok) cursor_next = pos_inc[PosW-1:0];
        else bell = 1'b1;
      end
      lec_pkg::OP_HOME, lec_pkg::OP_START: begin
        cursor_next = '0;
      end
      lec_pkg::OP_END: begin
        cursor_next = nul_len;
      end
      lec_pkg::OP_INS: begin
        mode_next = !insert_flag;
      end
      lec_pkg::OP_ENTER: begin
        done = 1'b1;
      end
      lec_pkg::OP_PRINT: begin
        if (cursor < w) begin
          if (insert_flag || pos_inc < {1'b0, w}) cursor_next = pos_inc[PosW-1:0];
          else cursor_next = w_m1;
        end
      end
      default: begin
        cursor_next = cursor;
      end
    endcase
  end

  assign res_load        = (state == ST_FINISH) && out_free;
  assign res.cursor      = cursor_next;
  assign res.insert_mode = mode_next;
  assign res.bell        = bell;
  assign res.done_res    = done;
  assign res.line_length = done ? nul_len : '0;
  assign res.read_char   = (op == lec_pkg::OP_READ) ? rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cnt            <= '0;
      cursor         <= '0;
      insert_flag    <= 1'b0;
      prefix_pending <= 1'b0;
      op             <= lec_pkg::OP_NONE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_ROTATE;
            cnt   <= '0;
            op    <= op_dec;
            if (action == lec_pkg::ACT_START) begin
              prefix_pending <= 1'b0;
            end else if (action == lec_pkg::ACT_KEY) begin
              prefix_pending <= (op_dec == lec_pkg::OP_PREFIX);
            end
          end
        end
        ST_ROTATE: begin
          cnt <= cnt + IdxW'(1);
          if (cnt == IdxW'(lec_pkg::MaxWidth - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state       <= ST_IDLE;
            cursor      <= cursor_next;
            insert_flag <= mode_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q     <= key_byte;
      idx_q     <= char_index;
      val_q     <= char_value;
      del_go    <= 1'b0;
      right_ok  <= 1'b0;
      nul_found <= 1'b0;
      nul_idx   <= '0;
      rd        <= '0;
    end else if (state == ST_ROTATE) begin
      prev   <= tap.head;
      del_go <= del_go || del_hit;
      if ({1'b0, t} == pos_inc) begin
        right_ok <= (tap.head != '0);
      end
      if (!nul_found && t < w && tap.head == '0) begin
        nul_found <= 1'b1;
        nul_idx   <= t;
      end
      if (cnt == idx_q) begin
        rd <= tap.head;
      end
    end
  end

  `LEC_ASSERT_NEXT(a_turn_ends, clk, rst,
    state == ST_ROTATE && cnt == IdxW'(lec_pkg::MaxWidth - 1), state == ST_FINISH)
  `LEC_ASSERT_NEXT(a_accept_starts_turn, clk, rst, accept,
    state == ST_ROTATE && cnt == '0)
  `LEC_ASSERT_NEXT(a_cursor_commit_only, clk, rst, state != ST_FINISH, $stable(cursor))
  `LEC_ASSERT_IMPL(a_cursor_range, clk, rst, 1'b1, cursor <= PosW'(lec_pkg::MaxWidth))

endmodule

/* src/line_edit_buffer_core.sv */
// Top level of the line edit buffer: configuration register, cell ring,
// sequencer and result register. Depends on lec_pkg, lec_chain and lec_ctrl.
`timescale 1ns / 1ps
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   action, key_byte, char_index, char_value
//   out      from block out_valid / out_stall cursor, insert_mode, bell, done_res,
//                                             line_length, read_char
//   cfg      to block   cfg_write_en          cfg_write_data (edit_width)
//
// Each item is accepted in the idle state, the 64-cell ring then makes one full turn
// (one cell per cycle), and a finish state, which waits while the output register is
// held, commits cursor and mode into the result register; then the next item is accepted.
// The next item is accepted while a result still waits in the output register.
// Reset clears cursor, mode, prefix state and the width register (to 64); the
// line characters are undefined until loaded.

module line_edit_buffer_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [lec_pkg::CfgW-1:0]  cfg_write_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lec_pkg::ActW-1:0]  action,
  input  logic [lec_pkg::CharW-1:0] key_byte,
  input  logic [lec_pkg::IdxW-1:0]  char_index,
  input  logic [lec_pkg::CharW-1:0] char_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lec_pkg::PosW-1:0]  cursor,
  output logic                      insert_mode,
  output logic                      bell,
  output logic                      done_res,
  output logic [lec_pkg::PosW-1:0]  line_length,
  output logic [lec_pkg::CharW-1:0] read_char
);

  logic [lec_pkg::CfgW-1:0] edit_width;
  lec_pkg::chain_ctl_t      ctl;
  lec_pkg::chain_tap_t      tap;
  lec_pkg::result_t         res;
  lec_pkg::result_t         res_q;
  logic                     res_load;
  logic                     out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      edit_width <= lec_pkg::CfgW'(lec_pkg::MaxWidth);
    end else if (cfg_write_en) begin
      edit_width <= cfg_write_data;
    end
  end

  lec_chain u_chain (
    .clk(clk),
    .ctl(ctl),
    .tap(tap)
  );

  lec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .key_byte  (key_byte),
    .char_index(char_index),
    .char_value(char_value),
    .edit_width(edit_width),
    .tap       (tap),
    .ctl       (ctl),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign cursor      = res_q.cursor;
  assign insert_mode = res_q.insert_mode;
  assign bell        = res_q.bell;
  assign done_res    = res_q.done_res;
  assign line_length = res_q.line_length;
  assign read_char   = res_q.read_char;

endmodule
